@@ hdl/rqe_pkg.sv @@
// ----------------------------------------------------------------------------
// rqe_pkg: shared definitions for the rotating queue with expedite
// Mode codes, the configuration width and the command and status groups
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package rqe_pkg;

	// Request mode field
	typedef logic [1:0] mode_t;

	localparam mode_t MODE_NEXT     = 2'd0;
	localparam mode_t MODE_EXPEDITE = 2'd1;
	localparam mode_t MODE_RESTART  = 2'd2;

	// Width of the initial_count register
	localparam int CFG_BITS = 7;

	// Commands from controller to datapath
	typedef struct packed {
		logic latch;        // capture the request identifier
		logic next_read;    // read the head entry
		logic next_commit;  // move head entry to tail and present it
		logic emit_empty;   // present an empty-list result
		logic ex_start;     // set up the expedite scan
		logic ex_step;      // advance the expedite scan
		logic ex_place;     // write the expedited identifier at the head
		logic fill_start;   // set up the restart fill
		logic fill_step;    // write one fill entry
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic count_zero;   // list holds no entries
		logic out_free;     // result register can take a result this cycle
		logic scan_done;    // expedite scan finished, nothing pending
		logic fill_done;    // all fill entries written
	} stat_t;

endpackage

@@ hdl/rqe_channels.sv @@
// ----------------------------------------------------------------------------
// rqe channel interfaces
// Request channel (mode, person_id) and result channel (served_id,
// queue_empty), each with valid/ready and source/sink modports.
// ----------------------------------------------------------------------------
interface rqe_req_if #(
	parameter int ID_BITS = 16
) ();
	logic                 valid;
	logic                 ready;
	rqe_pkg::mode_t       mode;
	logic [ID_BITS-1:0]   person_id;

	modport source (output valid, output mode, output person_id, input ready);
	modport sink   (input valid, input mode, input person_id, output ready);
endinterface

interface rqe_res_if #(
	parameter int ID_BITS = 16
) ();
	logic                 valid;
	logic                 ready;
	logic [ID_BITS-1:0]   served_id;
	logic                 queue_empty;

	modport source (output valid, output served_id, output queue_empty, input ready);
	modport sink   (input valid, input served_id, input queue_empty, output ready);
endinterface

@@ hdl/rqe_ctrl.sv @@
// ----------------------------------------------------------------------------
// rqe_ctrl: sequencing controller
// Accepts one request at a time and steps the datapath through the
// serve, expedite scan and restart fill sequences.
// ----------------------------------------------------------------------------
module rqe_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  rqe_pkg::mode_t  req_mode,
	output logic            req_ready,
	input  rqe_pkg::stat_t  stat,
	output rqe_pkg::cmd_t   cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_NX_READ  = 6'b000010,
		ST_NX_WRITE = 6'b000100,
		ST_EX_SCAN  = 6'b001000,
		ST_EX_PLACE = 6'b010000,
		ST_FILL     = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_mode)
						rqe_pkg::MODE_NEXT: begin
							state_d = ST_NX_READ;
						end
						rqe_pkg::MODE_EXPEDITE: begin
							cmd.latch    = 1'b1;
							cmd.ex_start = 1'b1;
							state_d      = ST_EX_SCAN;
						end
						rqe_pkg::MODE_RESTART: begin
							cmd.fill_start = 1'b1;
							state_d        = ST_FILL;
						end
						default: begin
							// unused mode: drop the transfer
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_NX_READ: begin
				if (stat.count_zero) begin
					if (stat.out_free) begin
						cmd.emit_empty = 1'b1;
						state_d        = ST_IDLE;
					end
				end else begin
					cmd.next_read = 1'b1;
					state_d       = ST_NX_WRITE;
				end
			end
			ST_NX_WRITE: begin
				if (stat.out_free) begin
					cmd.next_commit = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_EX_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_EX_PLACE;
				end else begin
					cmd.ex_step = 1'b1;
				end
			end
			ST_EX_PLACE: begin
				cmd.ex_place = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_FILL: begin
				if (stat.fill_done) begin
					state_d = ST_IDLE;
				end else begin
					cmd.fill_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/rqe_datapath.sv @@
// ----------------------------------------------------------------------------
// rqe_datapath: list memory, pointers and result register
// Holds the list as a circular buffer (head pointer plus count) in a
// single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rqe_datapath #(
	parameter int CAPACITY = 64,
	parameter int ID_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [rqe_pkg::CFG_BITS-1:0]  cfg_wdata,
	input  logic [ID_BITS-1:0]            req_id,
	input  rqe_pkg::cmd_t                 cmd,
	output rqe_pkg::stat_t                stat,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [ID_BITS-1:0]            res_id,
	output logic                          res_empty
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);

	logic [ID_BITS-1:0]           mem [CAPACITY];

	logic [rqe_pkg::CFG_BITS-1:0] cfg_q;
	logic [AW-1:0]                head_q;
	logic [CW-1:0]                count_q;
	logic [AW-1:0]                rp_q;
	logic [AW-1:0]                wp_q;
	logic [CW-1:0]                remain_q;
	logic [CW-1:0]                kept_q;
	logic                         pend_q;
	logic [CW-1:0]                fill_q;
	logic [ID_BITS-1:0]           id_q;
	logic [ID_BITS-1:0]           rd_q;
	logic                         out_valid_q;
	logic [ID_BITS-1:0]           out_id_q;
	logic                         out_empty_q;

	logic [SW-1:0]                sum;
	logic [AW-1:0]                end_addr;
	logic [AW-1:0]                last_addr;
	logic [AW-1:0]                head_inc;
	logic [AW-1:0]                rp_dec;
	logic [AW-1:0]                wp_dec;
	logic [CW-1:0]                fill_n;
	logic                         keep;
	logic                         scan_rd;
	logic                         mem_re;
	logic [AW-1:0]                mem_ra;
	logic                         mem_we;
	logic [AW-1:0]                mem_wa;
	logic [ID_BITS-1:0]           mem_wd;
	logic                         out_load;

	// Circular address arithmetic: slot past the tail, tail, wrapped steps
	always_comb begin
		sum = SW'(head_q) + SW'(count_q);
		if (sum >= SW'(CAPACITY)) begin
			sum = sum - SW'(CAPACITY);
		end
		end_addr  = sum[AW-1:0];
		last_addr = (end_addr == '0) ? LAST_ADDR : end_addr - AW'(1);
		head_inc  = (head_q == LAST_ADDR) ? '0 : head_q + AW'(1);
		rp_dec    = (rp_q == '0) ? LAST_ADDR : rp_q - AW'(1);
		wp_dec    = (wp_q == '0) ? LAST_ADDR : wp_q - AW'(1);
	end

	// Saturate the restart count to the capacity
	always_comb begin
		if (int'(cfg_q) > CAPACITY) begin
			fill_n = CAP_CNT;
		end else begin
			fill_n = CW'(cfg_q);
		end
	end

	// Memory port selection
	always_comb begin
		keep    = pend_q && (rd_q != id_q);
		scan_rd = cmd.ex_step && (remain_q != '0);
		mem_re  = cmd.next_read || scan_rd;
		mem_ra  = cmd.next_read ? head_q : rp_q;
		mem_we  = 1'b0;
		mem_wa  = wp_q;
		mem_wd  = rd_q;
		priority if (cmd.next_commit) begin
			mem_we = 1'b1;
			mem_wa = end_addr;
			mem_wd = rd_q;
		end else if (cmd.ex_step && keep) begin
			mem_we = 1'b1;
			mem_wa = wp_q;
			mem_wd = rd_q;
		end else if (cmd.ex_place) begin
			mem_we = 1'b1;
			mem_wa = wp_q;
			mem_wd = id_q;
		end else if (cmd.fill_step) begin
			mem_we = 1'b1;
			mem_wa = fill_q[AW-1:0];
			mem_wd = ID_BITS'(fill_q + CW'(1));
		end
	end

	// List memory with registered read data
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// Hold the expedite identifier
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			id_q <= req_id;
		end
	end

	// Configuration, pointers and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= '0;
			head_q   <= '0;
			count_q  <= '0;
			rp_q     <= '0;
			wp_q     <= '0;
			remain_q <= '0;
			kept_q   <= '0;
			pend_q   <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (cfg_wen) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.next_commit) begin
				head_q <= head_inc;
			end
			// set up a downward scan from the tail
			if (cmd.ex_start) begin
				rp_q     <= last_addr;
				wp_q     <= last_addr;
				remain_q <= count_q;
				kept_q   <= '0;
				pend_q   <= 1'b0;
			end
			// read one entry, compact the one read last cycle
			if (cmd.ex_step) begin
				pend_q <= scan_rd;
				if (scan_rd) begin
					rp_q     <= rp_dec;
					remain_q <= remain_q - CW'(1);
				end
				if (keep) begin
					wp_q   <= wp_dec;
					kept_q <= kept_q + CW'(1);
				end
			end
			// a full list with the identifier absent drops its tail here
			if (cmd.ex_place) begin
				head_q  <= wp_q;
				count_q <= (kept_q == CAP_CNT) ? CAP_CNT : kept_q + CW'(1);
			end
			if (cmd.fill_start) begin
				head_q  <= '0;
				count_q <= fill_n;
				fill_q  <= '0;
			end
			if (cmd.fill_step) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// Result register
	assign out_load = cmd.next_commit || cmd.emit_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_id_q    <= cmd.emit_empty ? '0 : rd_q;
			out_empty_q <= cmd.emit_empty;
		end
	end

	// Status to controller
	always_comb begin
		stat.count_zero = (count_q == '0);
		stat.out_free   = !out_valid_q || res_ready;
		stat.scan_done  = (remain_q == '0) && !pend_q;
		stat.fill_done  = (fill_q == count_q);
	end

	assign res_valid = out_valid_q;
	assign res_id    = out_id_q;
	assign res_empty = out_empty_q;

endmodule

@@ hdl/rotating_queue_with_expedite.sv @@
// ----------------------------------------------------------------------------
// rotating_queue_with_expedite: move-to-front service queue
// Serves identifiers from the head of an ordered list and rotates them to
// the tail; expedite moves an identifier to the head; restart refills 1..n.
//
//   channel   dir  handshake      payload
//   request   in   valid/ready    mode, person_id
//   result    out  valid/ready    served_id, queue_empty
//   cfg       in   cfg_wen        cfg_wdata (initial_count)
//
// One request is worked at a time over the single-write, single-read memory:
//   next     reads the head entry, then moves it to the tail and presents it
//            (an empty list presents an empty result); waits on a full result
//   expedite scans down from the tail, one entry read and
//            compacted per cycle, then writes the identifier at the head
//   restart  writes n entries, n = min(initial_count, CAPACITY)
// Reset empties the list; memory contents are not cleared.
// A waiting result does not block requests until the next serve needs it.
// ----------------------------------------------------------------------------
module rotating_queue_with_expedite #(
	parameter int CAPACITY = 64,
	parameter int ID_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [rqe_pkg::CFG_BITS-1:0]  cfg_wdata,
	rqe_req_if.sink                       request,
	rqe_res_if.source                     result
);

	rqe_pkg::cmd_t   cmd;
	rqe_pkg::stat_t  stat;
	logic            req_ready;

	// Sequencing controller
	rqe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_mode  (request.mode),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// List datapath
	rqe_datapath #(
		.CAPACITY (CAPACITY),
		.ID_BITS  (ID_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.req_id    (request.person_id),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_id    (result.served_id),
		.res_empty (result.queue_empty)
	);

	assign request.ready = req_ready;

endmodule

@@ hdl/rqe_checker.sv @@
// ----------------------------------------------------------------------------
// rqe_checker: port-level checks for the rotating queue
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rqe_checker #(
	parameter int ID_BITS = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input rqe_pkg::mode_t      req_mode,
	input logic                res_valid,
	input logic                res_ready,
	input logic [ID_BITS-1:0]  res_id,
	input logic                res_empty
);

	// Stalled result holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_id) && $stable(res_empty))
		else $error("result changed while stalled");

	// Empty result carries a zero identifier
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_empty |-> res_id == '0)
		else $error("empty result with nonzero identifier");

	// Any real request takes the block out of idle, so ready drops after the transfer
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_mode == rqe_pkg::MODE_NEXT ||
		req_mode == rqe_pkg::MODE_EXPEDITE || req_mode == rqe_pkg::MODE_RESTART)
		|=> !req_ready)
		else $error("ready right after a request transfer");

	// A new result appears only while a request is being worked
	a_res_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(req_ready))
		else $error("result produced while idle");

endmodule

bind rotating_queue_with_expedite rqe_checker #(
	.ID_BITS (ID_BITS)
) u_rqe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.req_mode  (request.mode),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_id    (result.served_id),
	.res_empty (result.queue_empty)
);
